### sv/block_rms_meter_macros.svh
// Assertion macros for the block RMS meter.
`ifndef BLOCK_RMS_METER_MACROS_SVH
`define BLOCK_RMS_METER_MACROS_SVH

`ifndef SYNTHESIS
`define BRMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BRMS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BRMS_ASSERT(name, prop, msg)
`define BRMS_ASSERT_NEVER(name, cond, msg)
`endif

`endif

### sv/brms_pkg.sv
package brms_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int RMS_W      = 16;
  localparam int CNT_OUT_W  = 13;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic take;
    logic start_div;
    logic div_step;
    logic start_root;
    logic root_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic root_last;
    logic out_free;
  } status_t;

endpackage

### sv/block_rms_meter.sv
// Block RMS meter.
// Input stream: one signed sample per word on s_tdata, s_tlast marks the
// last sample of a block. Samples are taken one per cycle; each one is
// squared and added to an exact running sum with a sample count.
// On the last sample the block stops taking words, divides the sum by the
// count (one quotient bit a cycle) and takes the integer square root of the
// mean (one root bit a cycle). The result word then appears on m_tvalid,
// and the meter then accepts the next block at once.
// Result word: rms_value, sample_count and the overflow flag in m_tuser.
// Samples beyond MAX_SAMPLES in a block are dropped and set overflow.
// The result sits in an output register; a stalled receiver does not block
// the next block's samples, only the next result, which waits until the
// register is free. Reset clears the sum, count, flag and any pending word.
module block_rms_meter #(
  parameter int MAX_SAMPLES = brms_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = brms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample
  input  logic                            s_tlast,   // last_sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [brms_pkg::OUT_DATA_W-1:0] m_tdata,   // rms_value, sample_count
  output logic                            m_tuser    // overflow
);
  import brms_pkg::*;

  `include "block_rms_meter_macros.svh"

  localparam int PAD_W = OUT_DATA_W - RMS_W - CNT_OUT_W;

  cmd_t                 cmd;
  status_t              status;
  logic [RMS_W-1:0]     rms_value;
  logic [CNT_OUT_W-1:0] sample_count;

  brms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  brms_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (s_tdata[SAMPLE_BITS-1:0]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .rms_value    (rms_value),
    .sample_count (sample_count),
    .overflow     (m_tuser)
  );

  assign m_tdata = {{PAD_W{1'b0}}, sample_count, rms_value};

  `BRMS_ASSERT(a_emit_into_free_slot, cmd.emit |-> (!m_tvalid || m_tready), "result overwritten")
  `BRMS_ASSERT(a_valid_from_emit, $rose(m_tvalid) |-> $past(cmd.emit), "result without emit")
  `BRMS_ASSERT(a_hold_after_last, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "word taken after last")
  `BRMS_ASSERT_NEVER(a_one_unit_busy, cmd.div_step && cmd.root_step, "divider and root both stepping")

endmodule

### sv/brms_ctrl.sv
module brms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  brms_pkg::status_t status,
  output brms_pkg::cmd_t    cmd
);
  import brms_pkg::*;

  typedef enum logic [6:0] {
    ST_ACCUM = 7'b0000001,
    ST_FLUSH = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_RLOAD = 7'b0010000,
    ST_ROOT  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    s_tready       = 1'b0;
    case (state)
      ST_ACCUM: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.start_div = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_RLOAD;
        end
      end
      ST_RLOAD: begin
        cmd.start_root = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

### sv/brms_dp.sv
module brms_dp #(
  parameter int MAX_SAMPLES = brms_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = brms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  brms_pkg::cmd_t                 cmd,
  output brms_pkg::status_t              status,
  input  logic [SAMPLE_BITS-1:0]         sample,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [brms_pkg::RMS_W-1:0]     rms_value,
  output logic [brms_pkg::CNT_OUT_W-1:0] sample_count,
  output logic                           overflow
);
  import brms_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int MEAN_W = 2 * SAMPLE_BITS - 1;
  localparam int ROOT_W = SAMPLE_BITS;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int STEP_W = $clog2(SUM_W);

  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq;
  logic                   sq_valid;
  logic [SUM_W-1:0]       square_sum;
  logic [CNT_W-1:0]       count;
  logic                   overflow_seen;

  logic [SUM_W-1:0]       quo;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       divisor;
  logic                   ovf_hold;
  logic [CNT_W:0]         div_trial;
  logic                   div_ge;
  logic [CNT_W:0]         div_diff;

  logic [RAD_W-1:0]       rad;
  logic [ROOT_W-1:0]      root;
  logic [ROOT_W+1:0]      srem;
  logic [ROOT_W+1:0]      rt_rem;
  logic [ROOT_W+1:0]      rt_trial;
  logic                   rt_ge;

  logic [STEP_W-1:0]      step;

  assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= cmd.take;
    end
    if (cmd.take) begin
      sq <= SQ_W'(PROD_W'(mag) * PROD_W'(mag));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start_div) begin
      square_sum    <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (sq_valid) begin
      if (count != CNT_W'(MAX_SAMPLES)) begin
        square_sum <= square_sum + SUM_W'(sq);
        count      <= count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  assign div_trial = {rem, quo[SUM_W-1]};
  assign div_ge    = div_trial >= {1'b0, divisor};
  assign div_diff  = div_trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      quo      <= square_sum;
      rem      <= '0;
      divisor  <= count;
      ovf_hold <= overflow_seen;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], div_ge};
      rem <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
    end
  end

  assign rt_rem   = {srem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign rt_trial = {root, 2'b01};
  assign rt_ge    = rt_rem >= rt_trial;

  always_ff @(posedge clk) begin
    if (cmd.start_root) begin
      rad  <= RAD_W'(quo[MEAN_W-1:0]);
      root <= '0;
      srem <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      root <= {root[ROOT_W-2:0], rt_ge};
      srem <= rt_ge ? (rt_rem - rt_trial) : rt_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start_div || cmd.start_root) begin
      step <= '0;
    end else if (cmd.div_step || cmd.root_step) begin
      step <= step + 1'b1;
    end
  end

  assign status.div_last  = step == STEP_W'(SUM_W - 1);
  assign status.root_last = step == STEP_W'(ROOT_W - 1);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.emit) begin
      rms_value    <= RMS_W'(root);
      sample_count <= CNT_OUT_W'(divisor);
      overflow     <= ovf_hold;
    end
  end

endmodule
